FILE: hw/rtl/signed_integer_square_root_unit_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the signed integer square root unit
// Shared property wrappers, clocked on i_clk and held off during reset.
// ---------------------------------------------------------------------------
`ifndef SIGNED_INTEGER_SQUARE_ROOT_UNIT_MACROS_SVH
`define SIGNED_INTEGER_SQUARE_ROOT_UNIT_MACROS_SVH

`ifndef ASSERT_OFF
// Same-cycle implication
`define SISQR_ASSERT_IMP(lbl, a, b) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (a) |-> (b)) \
        else $error("sisqr assertion failed");
// Next-cycle implication
`define SISQR_ASSERT_NXT(lbl, a, b) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (a) |=> (b)) \
        else $error("sisqr assertion failed");
`else
`define SISQR_ASSERT_IMP(lbl, a, b)
`define SISQR_ASSERT_NXT(lbl, a, b)
`endif

`endif

FILE: hw/rtl/sisqr_pkg.sv
// ---------------------------------------------------------------------------
// Signed integer square root package
// Fixed field widths shared by the stages and the top level.
// ---------------------------------------------------------------------------
package sisqr_pkg;

    // Operand field width on the request side
    localparam int OPERAND_W = 64;

    // Root field width and its byte-padded stream width
    localparam int ROOT_W    = 33;
    localparam int M_TDATA_W = ((ROOT_W + 7) / 8) * 8;

endpackage

FILE: hw/rtl/sisqr_front.sv
// ---------------------------------------------------------------------------
// Square root front stage
// Takes the low operand bits, registers the sign and the magnitude.
// ---------------------------------------------------------------------------
module sisqr_front #(
    parameter int DATA_WIDTH = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [sisqr_pkg::OPERAND_W-1:0] i_operand,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic                          o_neg,
    output logic [DATA_WIDTH-1:0]         o_mag
);

    logic                  r_valid;
    logic                  r_neg;
    logic [DATA_WIDTH-1:0] r_mag;
    logic [DATA_WIDTH-1:0] x;
    logic                  n_neg;
    logic [DATA_WIDTH-1:0] n_mag;

    // Accept when empty or when the held request moves on
    assign o_ready = !r_valid || i_ready;

    // Fold to magnitude; the most negative value maps to 2^(DATA_WIDTH-1)
    assign x     = i_operand[DATA_WIDTH-1:0];
    assign n_neg = x[DATA_WIDTH-1];
    assign n_mag = n_neg ? (~x + {{(DATA_WIDTH-1){1'b0}}, 1'b1}) : x;

    // Hold control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // Load payload
    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_neg <= n_neg;
            r_mag <= n_mag;
        end
    end

    assign o_valid = r_valid;
    assign o_neg   = r_neg;
    assign o_mag   = r_mag;

endmodule

FILE: hw/rtl/sisqr_cell.sv
// ---------------------------------------------------------------------------
// Square root digit cell
// One restoring digit step at a fixed trial bit, registered with handshake.
// ---------------------------------------------------------------------------
module sisqr_cell #(
    parameter int DATA_WIDTH = 64,
    parameter int BIT_POS    = 62
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic                  i_neg,
    input  logic [DATA_WIDTH-1:0] i_rem,
    input  logic [DATA_WIDTH-1:0] i_res,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic                  o_neg,
    output logic [DATA_WIDTH-1:0] o_rem,
    output logic [DATA_WIDTH-1:0] o_res
);

    localparam logic [DATA_WIDTH-1:0] TRIAL = {{(DATA_WIDTH-1){1'b0}}, 1'b1} << BIT_POS;

    logic                  r_valid;
    logic                  r_neg;
    logic [DATA_WIDTH-1:0] r_rem;
    logic [DATA_WIDTH-1:0] r_res;
    logic [DATA_WIDTH:0]   sum;
    logic                  fits;
    logic [DATA_WIDTH-1:0] n_rem;
    logic [DATA_WIDTH-1:0] n_res;

    // Accept when empty or when the held request moves on
    assign o_ready = !r_valid || i_ready;

    // Trial subtract of res + bit
    assign sum   = {1'b0, i_res} + {1'b0, TRIAL};
    assign fits  = {1'b0, i_rem} >= sum;
    assign n_rem = fits ? (i_rem - sum[DATA_WIDTH-1:0]) : i_rem;
    assign n_res = fits ? ((i_res >> 1) + TRIAL) : (i_res >> 1);

    // Hold control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // Load payload
    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_neg <= i_neg;
            r_rem <= n_rem;
            r_res <= n_res;
        end
    end

    assign o_valid = r_valid;
    assign o_neg   = r_neg;
    assign o_rem   = r_rem;
    assign o_res   = r_res;

endmodule

FILE: hw/rtl/sisqr_back.sv
// ---------------------------------------------------------------------------
// Square root output stage
// Applies the operand sign to the root and holds it for the consumer.
// ---------------------------------------------------------------------------
module sisqr_back #(
    parameter int DATA_WIDTH = 64
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic                           i_neg,
    input  logic [DATA_WIDTH-1:0]          i_res,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [sisqr_pkg::ROOT_W-1:0]   o_root
);

    logic                          r_valid;
    logic [sisqr_pkg::ROOT_W-1:0]  r_root;
    logic [sisqr_pkg::ROOT_W-1:0]  mag;
    logic [sisqr_pkg::ROOT_W-1:0]  n_root;

    // Fit the root to the output width
    generate
        if (DATA_WIDTH >= sisqr_pkg::ROOT_W) begin : g_trunc
            assign mag = i_res[sisqr_pkg::ROOT_W-1:0];
        end else begin : g_ext
            assign mag = {{(sisqr_pkg::ROOT_W-DATA_WIDTH){1'b0}}, i_res};
        end
    endgenerate

    // Negate for a negative operand
    assign n_root  = i_neg ? (~mag + {{(sisqr_pkg::ROOT_W-1){1'b0}}, 1'b1}) : mag;

    // Accept when empty or when the held result is taken
    assign o_ready = !r_valid || i_ready;

    // Hold control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // Load payload
    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_root <= n_root;
        end
    end

    assign o_valid = r_valid;
    assign o_root  = r_root;

endmodule

FILE: hw/rtl/signed_integer_square_root_unit.sv
// ---------------------------------------------------------------------------
// Signed integer square root unit
// Floor square root of a signed operand's magnitude, carrying its sign.
// ---------------------------------------------------------------------------
// The unit takes one operand per cycle while its output is not stalled and
// returns one root per operand, in order. A request passes a front stage
// (sign and magnitude), a chain of ((DATA_WIDTH-1)/2)+1 digit cells (32 for
// DATA_WIDTH = 64), each settling one root bit, and an output register that
// applies the sign. Every stage has its own valid bit and stalls only when
// its successor cannot accept, so bubbles close up under back-pressure; the
// throughput is one request per cycle while the consumer takes each result.
// Only the low DATA_WIDTH operand bits are read, as a two's complement number;
// the most negative value is rooted as the unsigned magnitude 2^(DATA_WIDTH-1).
// ---------------------------------------------------------------------------
`include "signed_integer_square_root_unit_macros.svh"

module signed_integer_square_root_unit #(
    parameter int DATA_WIDTH = 64
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // [63:0] operand
    input  logic [sisqr_pkg::OPERAND_W-1:0]   s_axis_tdata,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [32:0] root, [39:33] zero
    output logic [sisqr_pkg::M_TDATA_W-1:0]   m_axis_tdata
);

    localparam int TOP   = ((DATA_WIDTH - 1) / 2) * 2;
    localparam int STEPS = TOP / 2 + 1;

    logic                  c_valid [STEPS+1];
    logic                  c_ready [STEPS+1];
    logic                  c_neg   [STEPS+1];
    logic [DATA_WIDTH-1:0] c_rem   [STEPS+1];
    logic [DATA_WIDTH-1:0] c_res   [STEPS+1];
    logic [sisqr_pkg::ROOT_W-1:0] root;

    // Sign and magnitude
    sisqr_front #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (s_axis_tvalid),
        .o_ready   (s_axis_tready),
        .i_operand (s_axis_tdata),
        .o_valid   (c_valid[0]),
        .i_ready   (c_ready[0]),
        .o_neg     (c_neg[0]),
        .o_mag     (c_rem[0])
    );

    assign c_res[0] = '0;

    // Digit chain, trial bit moving down two places per cell
    generate
        for (genvar g = 0; g < STEPS; g++) begin : g_cell
            sisqr_cell #(
                .DATA_WIDTH (DATA_WIDTH),
                .BIT_POS    (TOP - 2 * g)
            ) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_valid (c_valid[g]),
                .o_ready (c_ready[g]),
                .i_neg   (c_neg[g]),
                .i_rem   (c_rem[g]),
                .i_res   (c_res[g]),
                .o_valid (c_valid[g+1]),
                .i_ready (c_ready[g+1]),
                .o_neg   (c_neg[g+1]),
                .o_rem   (c_rem[g+1]),
                .o_res   (c_res[g+1])
            );
        end
    endgenerate

    // Signed result register
    sisqr_back #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (c_valid[STEPS]),
        .o_ready (c_ready[STEPS]),
        .i_neg   (c_neg[STEPS]),
        .i_res   (c_res[STEPS]),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_root  (root)
    );

    assign m_axis_tdata = {{(sisqr_pkg::M_TDATA_W-sisqr_pkg::ROOT_W){1'b0}}, root};

    // An empty output register leaves the whole chain free to accept
    `SISQR_ASSERT_IMP(a_ready_when_drained, !m_axis_tvalid, s_axis_tready)
    // A result that is not taken stays on the bus unchanged
    `SISQR_ASSERT_NXT(a_result_held, m_axis_tvalid && !m_axis_tready,
                      m_axis_tvalid && $stable(m_axis_tdata))
    // The output register cannot become valid unless the last digit cell holds a request
    `SISQR_ASSERT_NXT(a_no_early_result, !m_axis_tvalid && !c_valid[STEPS],
                      !m_axis_tvalid)

endmodule
